// ===== design/tfnt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnt_pkg: shared types and constants
// Payload structs, register indexes and helpers for the face normal and
// tangent generator.
// ----------------------------------------------------------------------------
package tfnt_pkg;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] tex_u;
    logic signed [15:0] tex_v;
    logic signed [31:0] in_normal_x;
    logic signed [31:0] in_normal_y;
    logic signed [31:0] in_normal_z;
    logic signed [31:0] in_tangent_x;
    logic signed [31:0] in_tangent_y;
    logic signed [31:0] in_tangent_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic [1:0]         corner;
    logic               last;
    logic               degenerate;
  } out_item_t;

  localparam logic [0:0] REG_NORMAL_ENABLE  = 1'd0;
  localparam logic [0:0] REG_TANGENT_ENABLE = 1'd1;

  // Quotient scale: the tangent numerator is shifted left by this many bits.
  localparam int unsigned QSHIFT = 20;
  localparam int unsigned NUM_W  = 36;        // |numerator| < 2^35
  localparam int unsigned DIV_W  = NUM_W + QSHIFT;
  localparam int unsigned DEN_W  = 36;

  // Divider handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/triangle_flat_normal_tangent.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_flat_normal_tangent: per-face normal and tangent generator
// Collects triangle corners and emits per-corner normal and tangent results.
// ----------------------------------------------------------------------------
// Vertices of a triangle list arrive one transaction at a time. Corners 0 and
// 1 are held and accepted without stalling. The third corner starts a
// sequence on one shared 17x17 signed multiplier: the six cross-product terms,
// the determinant's two terms and six tangent numerator terms are formed in
// turn, then each of the three tangent components is divided by the
// determinant in a restoring divider that yields one quotient bit a cycle
// (56 quotient bits). The divider sets the pace, and the block does not
// accept input from the third corner until the last of its three results
// has entered the output register. Results come out of one output register
// in corner order, with last on corner 2. A zero determinant gives a zero
// tangent and sets degenerate while tangent computation is enabled;
// divisions are then skipped. With an enable cleared, each corner passes its
// own incoming vector through. All results saturate to 32-bit signed values;
// computed tangents are signed Q12.20. A partial triangle at the end never
// emits. Register writes are taken only while the block is collecting
// corners.
// ----------------------------------------------------------------------------
module triangle_flat_normal_tangent (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tfnt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tfnt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [0:0]          cfg_data
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_MUL     = 3'd1;
  localparam logic [2:0] ST_DIVGO   = 3'd2;
  localparam logic [2:0] ST_DIVWAIT = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] count_r, count_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [1:0] emit_r, emit_nxt;
  logic       nen_r, ten_r;

  tfnt_pkg::in_item_t held_r [3];

  logic signed [16:0] dp1 [3];
  logic signed [16:0] dp2 [3];
  logic signed [16:0] du1, dv1, du2, dv2;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic signed [35:0] acc_r [7];       // 0..2 normal, 3 det, 4..6 numerators
  logic signed [31:0] tan_r [3];
  logic               deg;
  logic               out_valid_r;
  tfnt_pkg::out_item_t out_r;
  tfnt_pkg::div_ctl_t  dctl;
  logic [tfnt_pkg::DIV_W-1:0] quo;
  logic [tfnt_pkg::NUM_W-1:0] num_abs;
  logic [tfnt_pkg::DEN_W-1:0] det_abs;
  logic                       qneg;
  logic [tfnt_pkg::DIV_W-1:0] qcl;
  logic signed [63:0]         qsig;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [15:0] a0, a1, a2;
      a0 = (k == 0) ? held_r[0].pos_x : (k == 1) ? held_r[0].pos_y : held_r[0].pos_z;
      a1 = (k == 0) ? held_r[1].pos_x : (k == 1) ? held_r[1].pos_y : held_r[1].pos_z;
      a2 = (k == 0) ? held_r[2].pos_x : (k == 1) ? held_r[2].pos_y : held_r[2].pos_z;
      dp1[k] = 17'(a1) - 17'(a0);
      dp2[k] = 17'(a2) - 17'(a0);
    end
    du1 = 17'(held_r[1].tex_u) - 17'(held_r[0].tex_u);
    dv1 = 17'(held_r[1].tex_v) - 17'(held_r[0].tex_v);
    du2 = 17'(held_r[2].tex_u) - 17'(held_r[0].tex_u);
    dv2 = 17'(held_r[2].tex_v) - 17'(held_r[0].tex_v);
  end

  // Operand selection for the shared multiplier; even steps load, odd subtract.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_r)
      4'd0:  begin ma = dp1[1]; mb = dp2[2]; end
      4'd1:  begin ma = dp1[2]; mb = dp2[1]; end
      4'd2:  begin ma = dp1[2]; mb = dp2[0]; end
      4'd3:  begin ma = dp1[0]; mb = dp2[2]; end
      4'd4:  begin ma = dp1[0]; mb = dp2[1]; end
      4'd5:  begin ma = dp1[1]; mb = dp2[0]; end
      4'd6:  begin ma = du1;    mb = dv2;    end
      4'd7:  begin ma = dv1;    mb = du2;    end
      4'd8:  begin ma = dp1[0]; mb = dv2;    end
      4'd9:  begin ma = dp2[0]; mb = dv1;    end
      4'd10: begin ma = dp1[1]; mb = dv2;    end
      4'd11: begin ma = dp2[1]; mb = dv1;    end
      4'd12: begin ma = dp1[2]; mb = dv2;    end
      4'd13: begin ma = dp2[2]; mb = dv1;    end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod = ma * mb;

  assign deg     = (acc_r[3] == '0);
  assign num_abs = acc_r[4 + comp_r][35] ? 36'(-acc_r[4 + comp_r]) : 36'(acc_r[4 + comp_r]);
  assign det_abs = acc_r[3][35] ? 36'(-acc_r[3]) : 36'(acc_r[3]);
  assign qneg    = acc_r[4 + comp_r][35] ^ acc_r[3][35];
  assign qcl     = (quo > 56'h80000000) ? 56'h80000000 : quo;
  assign qsig    = qneg ? -$signed({8'd0, qcl}) : $signed({8'd0, qcl});

  assign dctl.start = (state_r == ST_DIVGO);

  tfnt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dctl.start),
    .dividend ({num_abs, 20'd0}),
    .divisor  (det_abs),
    .busy     (dctl.busy),
    .quotient (quo)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    step_nxt  = step_r;
    comp_nxt  = comp_r;
    emit_nxt  = emit_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_valid) begin
          if (count_r == 2'd2) begin
            count_nxt = 2'd0;
            step_nxt  = 4'd0;
            state_nxt = ST_MUL;
          end else begin
            count_nxt = count_r + 2'd1;
          end
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd13) begin
          comp_nxt  = 2'd0;
          state_nxt = (ten_r && !deg) ? ST_DIVGO : ST_EMIT;
          emit_nxt  = 2'd0;
        end
      end
      ST_DIVGO: state_nxt = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (!dctl.busy) begin
          if (comp_r == 2'd2) begin
            state_nxt = ST_EMIT;
            emit_nxt  = 2'd0;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = ST_DIVGO;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit_nxt = emit_r + 2'd1;
          if (emit_r == 2'd2) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_COLLECT && in_valid) begin
      held_r[count_r] <= in_data;
    end
    if (state_r == ST_MUL) begin
      if (step_r <= 4'd5) begin
        if (!step_r[0]) acc_r[step_r[3:1]] <= 36'(prod);
        else acc_r[step_r[3:1]] <= acc_r[step_r[3:1]] - 36'(prod);
      end else begin
        if (!step_r[0]) acc_r[step_r[3:1]] <= 36'(prod);
        else acc_r[step_r[3:1]] <= acc_r[step_r[3:1]] - 36'(prod);
      end
    end
    if (state_r == ST_DIVWAIT && !dctl.busy) begin
      tan_r[comp_r] <= tfnt_pkg::sat32(qsig);
    end
    if (state_r == ST_EMIT && (!out_valid_r || !out_stall)) begin
      out_r.normal_x   <= nen_r ? tfnt_pkg::sat32(64'(acc_r[0])) : held_r[emit_r].in_normal_x;
      out_r.normal_y   <= nen_r ? tfnt_pkg::sat32(64'(acc_r[1])) : held_r[emit_r].in_normal_y;
      out_r.normal_z   <= nen_r ? tfnt_pkg::sat32(64'(acc_r[2])) : held_r[emit_r].in_normal_z;
      out_r.tangent_x  <= !ten_r ? held_r[emit_r].in_tangent_x : (deg ? '0 : tan_r[0]);
      out_r.tangent_y  <= !ten_r ? held_r[emit_r].in_tangent_y : (deg ? '0 : tan_r[1]);
      out_r.tangent_z  <= !ten_r ? held_r[emit_r].in_tangent_z : (deg ? '0 : tan_r[2]);
      out_r.corner     <= emit_r;
      out_r.last       <= (emit_r == 2'd2);
      out_r.degenerate <= ten_r && deg;
    end
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      step_r      <= '0;
      comp_r      <= '0;
      emit_r      <= '0;
      nen_r       <= 1'b1;
      ten_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
      emit_r  <= emit_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == tfnt_pkg::REG_NORMAL_ENABLE) nen_r <= cfg_data[0];
        if (cfg_index == tfnt_pkg::REG_TANGENT_ENABLE) ten_r <= cfg_data[0];
      end
      if (state_r == ST_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != ST_COLLECT);
  // The enables are sampled through the whole computation and emit sequence.
  assign cfg_ready = (state_r == ST_COLLECT);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/tfnt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfnt_div: restoring divider
// Unsigned division of a 56-bit dividend by a 36-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module tfnt_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tfnt_pkg::DIV_W-1:0]      dividend,
  input  logic [tfnt_pkg::DEN_W-1:0]      divisor,
  output logic                            busy,
  output logic [tfnt_pkg::DIV_W-1:0]      quotient
);

  logic [tfnt_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [tfnt_pkg::DEN_W:0]   rem_r, rem_nxt;
  logic [tfnt_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic [tfnt_pkg::DEN_W+1:0] trial;
  logic [tfnt_pkg::DEN_W:0]   shifted;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[tfnt_pkg::DEN_W-1:0], q_r[tfnt_pkg::DIV_W-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = 6'(tfnt_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[tfnt_pkg::DEN_W+1]) begin
        rem_nxt = trial[tfnt_pkg::DEN_W:0];
      end else begin
        rem_nxt = shifted;
      end
      q_nxt   = {q_r[tfnt_pkg::DIV_W-2:0], ~trial[tfnt_pkg::DEN_W+1]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule
